// ----- hdl/ptc_pkg.sv -----
// Package for the perceptron block: field widths, reset values, FSM state type,
// controller/datapath command and status structs, weight saturation helper.
// No dependencies.
package ptc_pkg;

  localparam int VEC_LEN_DEF = 64;

  localparam int COORD_W = 16;
  localparam int WGT_W   = 24;
  localparam int PROD_W  = COORD_W + WGT_W;
  localparam int ACC_W   = 48;
  localparam int DIM_W   = 7;
  localparam int EPS_W   = 32;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;

  localparam logic [DIM_W-1:0] DIM_RST = DIM_W'(2);
  localparam logic [EPS_W-1:0] EPS_RST = EPS_W'(1);

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_DIMENSION = 1'b0,
    REG_EPSILON   = 1'b1
  } reg_idx_t;

  typedef enum logic {
    MODE_TRAIN    = 1'b0,
    MODE_CLASSIFY = 1'b1
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_ACC,
    S_DECIDE,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic accept;  // take word: write buffer, launch weight read
    logic mul;     // register coordinate * weight
    logic acc;     // add product, advance count
    logic decide;  // load result, clear accumulator, arm walk
    logic walk;    // weight update walk step
  } ptc_cmd_t;

  typedef struct packed {
    logic last;       // this word completes the vector
    logic mismatch;   // training miss on the completed vector
    logic out_busy;   // result register still full
    logic walk_done;  // all weights written back
  } ptc_status_t;

  // w +/- x, clipped to the signed weight range
  function automatic logic [WGT_W-1:0] sat_update(input logic [WGT_W-1:0] w,
                                                  input logic [COORD_W-1:0] x,
                                                  input logic add);
    logic signed [WGT_W:0] ws;
    logic signed [WGT_W:0] xs;
    logic signed [WGT_W:0] s;
    logic signed [WGT_W:0] wmax;
    logic signed [WGT_W:0] wmin;
    ws   = (WGT_W+1)'($signed(w));
    xs   = (WGT_W+1)'($signed(x));
    wmax = (WGT_W+1)'({1'b0, {(WGT_W-1){1'b1}}});
    wmin = -wmax - (WGT_W+1)'(1);
    s    = add ? ws + xs : ws - xs;
    if (s > wmax) begin
      s = wmax;
    end else if (s < wmin) begin
      s = wmin;
    end
    return s[WGT_W-1:0];
  endfunction

endpackage

// ----- hdl/ptc_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ptc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ptc_ctrl.sv -----
// Perceptron controller FSM: sequences accept, multiply, accumulate, decide and
// the weight update walk. Depends on ptc_pkg.
module ptc_ctrl import ptc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ptc_status_t status,
  output ptc_cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.mul    = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = status.last ? S_DECIDE : S_IDLE;
      end
      S_DECIDE: begin
        if (!status.out_busy) begin
          cmd.decide = 1'b1;
          state_next = status.mismatch ? S_UPDATE : S_IDLE;
        end
      end
      S_UPDATE: begin
        cmd.walk = 1'b1;
        if (status.walk_done) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- hdl/ptc_datapath.sv -----
// Perceptron datapath: vector buffer and weight RAMs, weight valid bits, MAC,
// sign decision, saturating update walk, result register. Depends on ptc_pkg, ptc_ram.
module ptc_datapath import ptc_pkg::*; #(
  parameter int VEC_LEN = VEC_LEN_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  ptc_cmd_t           cmd,
  output ptc_status_t        status,
  input  logic [DIM_W-1:0]   dimension,
  input  logic [EPS_W-1:0]   epsilon,
  input  logic               in_mode,
  input  logic [COORD_W-1:0] in_coordinate,
  input  logic               in_label,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_pred,
  output logic               out_upd
);

  localparam int AW    = (VEC_LEN > 1) ? $clog2(VEC_LEN) : 1;
  localparam int CNT_W = $clog2(VEC_LEN + 1);
  localparam int EW    = ((CNT_W > DIM_W) ? CNT_W : DIM_W) + 1;

  logic [COORD_W-1:0] coord_q;
  logic               mode_q;
  logic               label_q;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   rd_ptr;
  logic               wr_v;
  logic [AW-1:0]      wr_addr;
  logic [VEC_LEN-1:0] wvalid;
  logic               wvalid_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]   acc;

  logic [EW-1:0]      dim_ext;
  logic [EW-1:0]      vl_ext;
  logic [EW-1:0]      dim_eff;
  logic [AW-1:0]      idx;
  logic [AW-1:0]      w_raddr;
  logic [WGT_W-1:0]   w_rdata;
  logic [WGT_W-1:0]   w_rd;
  logic [COORD_W-1:0] b_rdata;
  logic               w_we;
  logic [WGT_W-1:0]   w_wdata;
  logic               pred;
  logic               rd_more;

  // effective dimension: zero reads as one, clamp to buffer length
  assign dim_ext = EW'(dimension);
  assign vl_ext  = EW'(VEC_LEN);
  assign dim_eff = (dim_ext == '0) ? EW'(1) : ((dim_ext > vl_ext) ? vl_ext : dim_ext);

  assign idx     = count[AW-1:0];
  assign w_raddr = cmd.walk ? rd_ptr[AW-1:0] : idx;
  assign w_rd    = wvalid_q ? w_rdata : '0;
  assign rd_more = EW'(rd_ptr) < dim_eff;

  assign w_we    = cmd.walk && wr_v;
  assign w_wdata = sat_update(w_rd, b_rdata, label_q);

  ptc_ram #(.WIDTH(WGT_W), .DEPTH(VEC_LEN)) u_wgt_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (wr_addr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  ptc_ram #(.WIDTH(COORD_W), .DEPTH(VEC_LEN)) u_buf_ram (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (idx),
    .wdata (in_coordinate),
    .raddr (rd_ptr[AW-1:0]),
    .rdata (b_rdata)
  );

  // negative or below epsilon is minus
  assign pred = !acc[ACC_W-1] && (acc >= ACC_W'(epsilon));

  assign status.last      = (EW'(count) + EW'(1)) >= dim_eff;
  assign status.mismatch  = (mode_q == MODE_TRAIN) && (pred != label_q);
  assign status.out_busy  = out_valid;
  assign status.walk_done = !rd_more && !wr_v;

  // payload
  always_ff @(posedge clk) begin
    wvalid_q <= wvalid[w_raddr];
    if (cmd.accept) begin
      coord_q <= in_coordinate;
      mode_q  <= in_mode;
      label_q <= in_label;
    end
    if (cmd.mul) begin
      prod_q <= $signed(coord_q) * $signed(w_rd);
    end
    if (cmd.walk && rd_more) begin
      wr_addr <= rd_ptr[AW-1:0];
    end
    if (cmd.decide) begin
      out_pred <= pred;
      out_upd  <= status.mismatch;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      wvalid    <= '0;
      acc       <= '0;
      count     <= '0;
      rd_ptr    <= '0;
      wr_v      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (w_we) begin
        wvalid[wr_addr] <= 1'b1;
      end
      if (cmd.acc) begin
        acc   <= acc + ACC_W'(prod_q);
        count <= status.last ? '0 : count + CNT_W'(1);
      end
      if (cmd.decide) begin
        acc    <= '0;
        rd_ptr <= '0;
        wr_v   <= 1'b0;
      end else if (cmd.walk) begin
        wr_v <= rd_more;
        if (rd_more) begin
          rd_ptr <= rd_ptr + CNT_W'(1);
        end
      end
      if (cmd.decide) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    EW'(count) < vl_ext)
    else $error("coordinate count reached buffer length");

  a_walk_addr: assert property (@(posedge clk) disable iff (rst)
    wr_v |-> (EW'(wr_addr) < dim_eff))
    else $error("weight write-back beyond dimension");

  a_walk_only: assert property (@(posedge clk) disable iff (rst)
    wr_v |-> cmd.walk)
    else $error("pending weight write outside update walk");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.decide |-> !out_valid)
    else $error("result loaded over a pending result");

endmodule

// ----- hdl/perceptron_train_and_classify.sv -----
// Perceptron, trained and queried one coordinate per word; depends on ptc_pkg, ptc_ctrl,
// ptc_datapath and ptc_ram. Each word passes accept, weight read+multiply and accumulate
// before the next word is taken. The result is registered after the closing word passes fetch,
// accumulate and decide; decide waits while the previous result is still unread.
// A training miss then walks the weight RAM before the next word is taken.
// Reset (rst, synchronous): weights read as zero, count/accumulator cleared, dim=2, eps=1.
module perceptron_train_and_classify import ptc_pkg::*; #(
  parameter int VEC_LEN = VEC_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // input stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,   // [15:0] coordinate, [16] label_positive, rest zero
  input  logic              s_tuser,   // [0] mode (0 train, 1 classify)
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,   // [0] predicted_positive, [1] weights_updated
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  ptc_cmd_t    cmd;
  ptc_status_t status;

  logic [DIM_W-1:0] dimension;
  logic [EPS_W-1:0] epsilon;
  logic             cfg_wr;
  reg_idx_t         reg_sel;
  logic             out_pred;
  logic             out_upd;

  // ---- configuration registers ----
  // one register per 32-bit word; paddr[2] selects it
  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension <= DIM_RST;
      epsilon   <= EPS_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_DIMENSION: dimension <= pwdata[DIM_W-1:0];
        REG_EPSILON:   epsilon   <= pwdata[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_DIMENSION: prdata = DATA_W'(dimension);
      REG_EPSILON:   prdata = DATA_W'(epsilon);
      default:       prdata = '0;
    endcase
  end

  // ---- controller: one word in flight, update walk blocks input ----
  ptc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  // ---- datapath: RAMs, MAC, decision, result register ----
  ptc_datapath #(.VEC_LEN(VEC_LEN)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .dimension     (dimension),
    .epsilon       (epsilon),
    .in_mode       (s_tuser),
    .in_coordinate (s_tdata[COORD_W-1:0]),
    .in_label      (s_tdata[COORD_W]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_pred      (out_pred),
    .out_upd       (out_upd)
  );

  // result word stays in the datapath register until taken
  assign m_tdata = {6'b0, out_upd, out_pred};

endmodule

// ----- tb/ptc_result_checker.sv -----
// Scoreboard for the perceptron block: follows the register port and both streams,
// keeps its own copy of weights, buffer and accumulator, and checks each result word.
// Depends on ptc_pkg.
`timescale 1ns / 100ps

module ptc_result_checker import ptc_pkg::*; #(
  parameter int VEC_LEN = VEC_LEN_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tready,
  input  logic [23:0]       s_tdata,   // [15:0] coordinate, [16] label_positive
  input  logic              s_tuser,   // [0] mode
  input  logic              m_tvalid,
  input  logic              m_tready,
  input  logic [7:0]        m_tdata,   // [0] predicted_positive, [1] weights_updated
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic [DATA_W-1:0] prdata,
  input  logic              pready,
  output int                mism_count,
  output int                outstanding
);

  localparam longint WGT_HI = (longint'(1) <<< (WGT_W - 1)) - 1;
  localparam longint WGT_LO = -(longint'(1) <<< (WGT_W - 1));

  typedef struct packed {
    logic weights_updated;
    logic predicted_positive;
  } verdict_t;

  logic signed [WGT_W-1:0]   weight_mem [VEC_LEN];
  logic signed [COORD_W-1:0] vec_mem    [VEC_LEN];
  logic signed [ACC_W-1:0]   dot_sum;
  int unsigned               coord_idx;
  logic [DIM_W-1:0]          dim_reg;
  logic [EPS_W-1:0]          eps_reg;
  verdict_t                  verdict_q [$];

  // One coordinate into the perceptron; queues a verdict when it closes a vector.
  task automatic absorb_coordinate(input mode_t md, input logic signed [COORD_W-1:0] crd,
                                   input logic lbl);
    int unsigned dim_eff;
    longint      prod;
    longint      sum;
    longint      mag;
    longint      w;
    verdict_t    v;
    dim_eff = (dim_reg == '0) ? 1 : (dim_reg > VEC_LEN) ? VEC_LEN : dim_reg;
    if (coord_idx < VEC_LEN) begin
      prod = longint'(crd) * longint'(weight_mem[coord_idx]);
      vec_mem[coord_idx] = crd;
      dot_sum = dot_sum + prod[ACC_W-1:0];
    end
    coord_idx++;
    if (coord_idx >= dim_eff) begin
      sum = longint'(dot_sum);
      mag = (sum < 0) ? -sum : sum;
      v.predicted_positive = !(mag < longint'(eps_reg) || sum < 0);
      v.weights_updated = 1'b0;
      if (md == MODE_TRAIN && v.predicted_positive != lbl) begin
        for (int i = 0; i < dim_eff; i++) begin
          w = longint'(weight_mem[i]) + (lbl ? longint'(vec_mem[i]) : -longint'(vec_mem[i]));
          if (w > WGT_HI) w = WGT_HI;
          if (w < WGT_LO) w = WGT_LO;
          weight_mem[i] = w[WGT_W-1:0];
        end
        v.weights_updated = 1'b1;
      end
      verdict_q.push_back(v);
      dot_sum = '0;
      coord_idx = 0;
    end
  endtask

  always @(posedge clk) begin : watch
    verdict_t          exp_v;
    logic [DATA_W-1:0] rd_exp;
    if (rst) begin
      foreach (weight_mem[i]) weight_mem[i] = '0;
      dot_sum = '0;
      coord_idx = 0;
      dim_reg = DIM_RST;
      eps_reg = EPS_RST;
      verdict_q.delete();
      mism_count = 0;
    end else begin
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (reg_idx_t'(paddr[2]))
            REG_DIMENSION: dim_reg = pwdata[DIM_W-1:0];
            REG_EPSILON:   eps_reg = pwdata[EPS_W-1:0];
            default: ;
          endcase
        end else begin
          rd_exp = (reg_idx_t'(paddr[2]) == REG_EPSILON) ? DATA_W'(eps_reg)
                                                         : DATA_W'(dim_reg);
          if (prdata !== rd_exp) begin
            $display("%0t: register read at %0d expected %08h actual %08h",
                     $time, paddr, rd_exp, prdata);
            mism_count++;
          end
        end
      end
      // results first: a word accepted on this edge cannot already have its result
      if (m_tvalid && m_tready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result word %02h with nothing expected", $time, m_tdata);
          mism_count++;
        end else begin
          exp_v = verdict_q.pop_front();
          if (m_tdata[0] !== exp_v.predicted_positive) begin
            $display("%0t: predicted_positive expected %0b actual %0b",
                     $time, exp_v.predicted_positive, m_tdata[0]);
            mism_count++;
          end
          if (m_tdata[1] !== exp_v.weights_updated) begin
            $display("%0t: weights_updated expected %0b actual %0b",
                     $time, exp_v.weights_updated, m_tdata[1]);
            mism_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        absorb_coordinate(mode_t'(s_tuser), s_tdata[COORD_W-1:0], s_tdata[COORD_W]);
      end
    end
    outstanding = verdict_q.size();
  end

endmodule

// ----- tb/tb_perceptron_train_and_classify.sv -----
// Top of the perceptron testbench: clock, reset, register writes, coordinate stimulus
// and result-side backpressure; checking is done by ptc_result_checker.
// Depends on ptc_pkg, ptc_result_checker and the perceptron RTL.
`timescale 1ns / 100ps

module tb_perceptron_train_and_classify;
  import ptc_pkg::*;

  // drain after the results; long enough for the weight RAM walk, decide and pipeline
  localparam int DRAIN_CYCLES = 80;
  localparam int SETTLE_LIMIT = 20000;
  // watchdog timeout in ns; a correct run needs well under a fifth of that
  localparam longint WATCHDOG_NS = 20_000_000;
  localparam int PHASE_WORDS = 140;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [23:0]       s_tdata = '0;   // [15:0] coordinate, [16] label_positive
  logic              s_tuser = 1'b0; // [0] mode
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;        // [0] predicted_positive, [1] weights_updated
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mism_count;
  int outstanding;

  // idle percentages, changed per phase
  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  // dimension as the block applies it (zero -> one, clipped to VEC_LEN)
  int vec_dim = 2;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  perceptron_train_and_classify DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ptc_result_checker checker_i (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .mism_count  (mism_count),
    .outstanding (outstanding)
  );

  // Result side: ready drawn fresh every cycle, so stalls land on any phase.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Mostly full-range coordinates, with the extremes, zero and small values mixed in.
  function automatic logic [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return COORD_W'($urandom_range(0, 1023) - 512);
      3:       return '0;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // One coordinate word. Valid is left high after the handshake and only dropped
  // by an idle cycle, so it never gets two assignments in one step.
  task automatic send_word(input mode_t md, input logic [COORD_W-1:0] crd, input logic lbl);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(24 - COORD_W - 1){1'b0}}, lbl, crd};
    s_tuser  <= md;
    do @(posedge clk); while (!s_tready);
  endtask

  // A run of len words; only the closing word's mode and label matter to the block,
  // the earlier ones carry random values on purpose.
  task automatic send_vector(input int len, input mode_t md, input logic lbl);
    for (int i = 0; i < len - 1; i++) begin
      send_word(mode_t'($urandom_range(0, 1)), pick_coord(), 1'($urandom_range(0, 1)));
    end
    send_word(md, pick_coord(), lbl);
  endtask

  // Stop sending, let every expected result drain, then give the weight walk time
  // to finish (a partial vector produces nothing to wait on).
  task automatic settle();
    int guard;
    guard = 0;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 && guard < SETTLE_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB transfer: setup cycle, then access until pready; ends in the cycle after
  // psel drops so back-to-back calls never collide in one step.
  task automatic reg_access(input reg_idx_t idx, input logic wr, input logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Reconfigure only with the block quiet; both registers read back for the checker.
  task automatic configure(input logic [DIM_W-1:0] dim, input logic [EPS_W-1:0] eps);
    settle();
    reg_access(REG_DIMENSION, 1'b1, DATA_W'(dim));
    reg_access(REG_EPSILON, 1'b1, DATA_W'(eps));
    reg_access(REG_DIMENSION, 1'b0, '0);
    reg_access(REG_EPSILON, 1'b0, '0);
    vec_dim = (dim == '0) ? 1 : (dim > VEC_LEN_DEF) ? VEC_LEN_DEF : int'(dim);
  endtask

  initial begin : stimulus
    int           ph;
    int           words;
    int           cut;
    logic [DIM_W-1:0] ph_dim;
    logic [EPS_W-1:0] ph_eps;
    mode_t        md;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset values of both registers
    reg_access(REG_DIMENSION, 1'b0, '0);
    reg_access(REG_EPSILON, 1'b0, '0);

    // ---- directed part, reset setting dim=2, eps=1 ----
    // zero weights: dot is zero, below eps=1 -> minus; first word's train/label ignored
    send_word(MODE_TRAIN, 16'h7FFF, 1'b1);
    send_word(MODE_CLASSIFY, 16'h8000, 1'b0);
    // training miss on extreme coordinates -> weights become (7FFF, -8000)
    send_word(MODE_CLASSIFY, 16'h7FFF, 1'b0);
    send_word(MODE_TRAIN, 16'h8000, 1'b1);
    // strongly negative dot, label minus agrees -> no update
    send_word(MODE_TRAIN, 16'h8000, 1'b1);
    send_word(MODE_TRAIN, 16'h7FFF, 1'b0);
    // classify with a mismatching label never updates
    send_word(MODE_CLASSIFY, 16'h0001, 1'b1);
    send_word(MODE_CLASSIFY, 16'hFFFF, 1'b0);

    // eps zero: a zero dot product is plus
    configure(7'd2, '0);
    send_word(MODE_TRAIN, 16'h0000, 1'b0);
    send_word(MODE_TRAIN, 16'h0000, 1'b1);
    send_word(MODE_TRAIN, 16'h0000, 1'b0);
    send_word(MODE_TRAIN, 16'h0000, 1'b0);

    // dimension zero acts as one; widest dead zone
    configure('0, '1);
    send_word(MODE_TRAIN, 16'h7FFF, 1'b1);
    send_word(MODE_TRAIN, 16'h8000, 1'b1);

    // dimension shrunk under a half-filled vector: next word closes it
    configure(7'd5, 32'd1);
    send_word(MODE_TRAIN, 16'h1234, 1'b0);
    send_word(MODE_TRAIN, 16'hEDCB, 1'b1);
    send_word(MODE_CLASSIFY, 16'h0100, 1'b0);
    configure(7'd2, 32'd1);
    send_word(MODE_TRAIN, 16'h8001, 1'b1);

    // ---- random part: twelve settings, idle pattern rotating through four modes ----
    for (ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       ph_dim = 7'd1;
        1:       ph_dim = 7'd2;
        2:       ph_dim = 7'd3;
        3:       ph_dim = 7'd127;  // clipped to VEC_LEN
        4:       ph_dim = 7'd5;
        5:       ph_dim = 7'd0;    // acts as one
        6:       ph_dim = 7'd8;
        7:       ph_dim = 7'd16;
        8:       ph_dim = 7'd64;
        9:       ph_dim = DIM_W'($urandom_range(1, 12));
        10:      ph_dim = 7'd4;
        default: ph_dim = 7'd2;
      endcase
      case (ph % 6)
        0:       ph_eps = 32'd1;
        1:       ph_eps = '0;
        2:       ph_eps = '1;
        3:       ph_eps = $urandom;
        4:       ph_eps = $urandom_range(0, 32'h00FF_FFFF);
        default: ph_eps = $urandom_range(0, 255);
      endcase
      configure(ph_dim, ph_eps);

      case (ph % 4)
        0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1:       begin src_idle_pct = 65; sink_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  sink_stall_pct = 65; end
        default: begin src_idle_pct = 16; sink_stall_pct = 16; end
      endcase

      words = 0;
      while (words < PHASE_WORDS) begin
        md = ($urandom_range(0, 3) == 0) ? MODE_CLASSIFY : MODE_TRAIN;
        send_vector(vec_dim, md, 1'($urandom_range(0, 1)));
        words += vec_dim;
      end

      // often leave a vector half done so the next setting lands mid-vector
      cut = $urandom_range(0, vec_dim - 1);
      for (int i = 0; i < cut; i++) begin
        send_word(mode_t'($urandom_range(0, 1)), pick_coord(), 1'($urandom_range(0, 1)));
      end
    end

    settle();
    if (outstanding != 0) begin
      $display("%0t: %0d results never arrived", $time, outstanding);
    end
    if (mism_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
